// File: design/key_value_table_unit_defines.svh
// ---------------------------------------------------------------------------
// Key/value table assertion macros
// Shared concurrent assertion wrappers, clocked on clk; KVT_ASSERT is gated by rst_n.
// ---------------------------------------------------------------------------
`ifndef KEY_VALUE_TABLE_UNIT_DEFINES_SVH
`define KEY_VALUE_TABLE_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked only while the block is out of reset.
`define KVT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define KVT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KVT_ASSERT(lbl, prop, msg)
`define KVT_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// File: design/kvt_pkg.sv
// ---------------------------------------------------------------------------
// Key/value table package
// Field widths, request codes and the controller/datapath interface types.
// ---------------------------------------------------------------------------
package kvt_pkg;

  localparam int DEF_CAPACITY = 16;

  localparam int REQ_W       = 2;
  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;
  localparam int CNT_OUT_W   = 5;
  localparam int IN_TDATA_W  = KEY_W + VAL_W;
  localparam int OUT_TDATA_W = ((VAL_W + CNT_OUT_W + 7) / 8) * 8;
  localparam int OUT_TUSER_W = 2;

  localparam logic [VAL_W-1:0] NO_VALUE = '1;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOOKUP = 2'd0,
    REQ_DEFINE = 2'd1,
    REQ_ERASE  = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    WR_NONE   = 2'd0,
    WR_UPDATE = 2'd1,
    WR_APPEND = 2'd2,
    WR_MOVE   = 2'd3
  } wr_op_t;

  typedef struct packed {
    logic   load;
    logic   scan_step;
    logic   rd_last;
    wr_op_t wr_op;
    logic   flag_full;
    logic   push;
  } kvt_cmd_t;

  typedef struct packed {
    req_t req;
    logic hit;
    logic miss;
    logic full;
    logic out_busy;
  } kvt_sts_t;

endpackage

// File: design/key_value_table_unit.sv
// ---------------------------------------------------------------------------
// Key/value table unit
// Associative table of unique keys with values, searched linearly.
// ---------------------------------------------------------------------------
// Requests arrive on the in_ stream: tuser carries the request kind (lookup,
// define or erase), tdata the key and the value to store. Each request gives
// exactly one result on the out_ stream: tdata the read value (all ones when
// there is none) and the entry count afterwards, tuser the found and
// full-error flags.
// One request is worked on at a time. The key and value memories are swept
// one entry per cycle through a registered read port, and the sweep stops at
// the first match; an unused request code goes straight to the result. A
// define that writes then passes through an update or append state, and an
// erase that matches through a fetch and a move state, which fetch the last
// entry and move it into the freed slot. The next request is accepted in the
// cycle after the result is registered, even while that result still waits
// to be taken.
// Reset empties the table at once; the memories are not cleared, as only
// entries below the count are ever read. When the receiver stalls, the
// finished result holds in the output register and the controller waits
// before registering the next one.
// ---------------------------------------------------------------------------
module key_value_table_unit #(
  parameter int CAPACITY = kvt_pkg::DEF_CAPACITY
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // Fields from bit 0: key [31:0], new_value [63:32].
  input  logic [kvt_pkg::IN_TDATA_W-1:0]     in_tdata,
  // Fields from bit 0: req_type [1:0].
  input  logic [kvt_pkg::REQ_W-1:0]          in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // Fields from bit 0: read_value [31:0], entry_count [36:32], zero fill [39:37].
  output logic [kvt_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // Fields from bit 0: found [0], full_error [1].
  output logic [kvt_pkg::OUT_TUSER_W-1:0]    out_tuser
);
  import kvt_pkg::*;

  localparam int PAD_W = OUT_TDATA_W - VAL_W - CNT_OUT_W;

  kvt_cmd_t             cmd;
  kvt_sts_t             sts;
  logic                 res_found;
  logic [VAL_W-1:0]     res_value;
  logic                 res_full;
  logic [CNT_OUT_W-1:0] res_count;

  // Controller: one request in flight, sequencing the datapath.
  kvt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: memories, scan pipeline and the output register.
  kvt_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_tuser),
    .in_key    (in_tdata[KEY_W-1:0]),
    .in_val    (in_tdata[KEY_W+VAL_W-1:KEY_W]),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_found (res_found),
    .out_value (res_value),
    .out_full  (res_full),
    .out_count (res_count)
  );

  assign out_tdata = {{PAD_W{1'b0}}, res_count, res_value};
  assign out_tuser = {res_full, res_found};

endmodule

// File: design/kvt_dp.sv
// ---------------------------------------------------------------------------
// Key/value table datapath
// Request registers, key and value memories, scan pipeline and result register.
// ---------------------------------------------------------------------------
`include "key_value_table_unit_defines.svh"

module kvt_dp #(
  parameter int CAPACITY = kvt_pkg::DEF_CAPACITY
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [kvt_pkg::REQ_W-1:0]       in_req,
  input  logic [kvt_pkg::KEY_W-1:0]       in_key,
  input  logic [kvt_pkg::VAL_W-1:0]       in_val,
  input  kvt_pkg::kvt_cmd_t               cmd,
  output kvt_pkg::kvt_sts_t               sts,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic                            out_found,
  output logic [kvt_pkg::VAL_W-1:0]       out_value,
  output logic                            out_full,
  output logic [kvt_pkg::CNT_OUT_W-1:0]   out_count
);
  import kvt_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [KEY_W-1:0] key_mem [CAPACITY];
  logic [VAL_W-1:0] val_mem [CAPACITY];

  req_t             req_r;
  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] val_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] scan_cnt_r;
  logic             cmp_vld_r;
  logic [IDX_W-1:0] cmp_idx_r;
  logic [IDX_W-1:0] slot_r;
  logic [KEY_W-1:0] key_rd_r;
  logic [VAL_W-1:0] val_rd_r;
  logic             found_r;
  logic             full_r;
  logic [VAL_W-1:0] res_val_r;

  logic             out_valid_r;
  logic             out_found_r;
  logic [VAL_W-1:0] out_value_r;
  logic             out_full_r;
  logic [CNT_OUT_W-1:0] out_count_r;

  logic             issue_ok;
  logic             hit;
  logic             is_full;
  logic [IDX_W-1:0] last_idx;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  logic             key_we;
  logic             val_we;
  logic [KEY_W-1:0] wr_key;
  logic [VAL_W-1:0] wr_val;

  assign issue_ok = (scan_cnt_r < count_r);
  assign hit      = cmp_vld_r && (key_rd_r == key_r);
  assign is_full  = (count_r == CNT_W'(CAPACITY));
  assign last_idx = IDX_W'(count_r - 1'b1);
  assign rd_addr  = cmd.rd_last ? last_idx : scan_cnt_r[IDX_W-1:0];

  always_comb begin
    wr_addr = slot_r;
    key_we  = 1'b0;
    val_we  = 1'b0;
    wr_key  = key_r;
    wr_val  = val_r;
    case (cmd.wr_op)
      WR_UPDATE: begin
        val_we = 1'b1;
      end
      WR_APPEND: begin
        wr_addr = count_r[IDX_W-1:0];
        key_we  = 1'b1;
        val_we  = 1'b1;
      end
      WR_MOVE: begin
        key_we = 1'b1;
        val_we = 1'b1;
        wr_key = key_rd_r;
        wr_val = val_rd_r;
      end
      default: begin
        key_we = 1'b0;
      end
    endcase
  end

  // Both memories share one read address and one write address.
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[wr_addr] <= wr_key;
    end
    key_rd_r <= key_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[wr_addr] <= wr_val;
    end
    val_rd_r <= val_mem[rd_addr];
  end

  // Request payload and per-request results.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r     <= req_t'(in_req);
      key_r     <= in_key;
      val_r     <= in_val;
      found_r   <= 1'b0;
      full_r    <= 1'b0;
      res_val_r <= NO_VALUE;
    end else begin
      if (cmd.scan_step && hit) begin
        found_r <= 1'b1;
        slot_r  <= cmp_idx_r;
        if (req_r == REQ_LOOKUP) begin
          res_val_r <= val_rd_r;
        end
      end
      if (cmd.flag_full) begin
        full_r <= 1'b1;
      end
    end
    if (cmd.scan_step) begin
      cmp_idx_r <= scan_cnt_r[IDX_W-1:0];
    end
    if (cmd.push) begin
      out_found_r <= found_r;
      out_value_r <= res_val_r;
      out_full_r  <= full_r;
      out_count_r <= CNT_OUT_W'(count_r);
    end
  end

  // Control state: entry count, scan pointer and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      scan_cnt_r  <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        scan_cnt_r <= '0;
        cmp_vld_r  <= 1'b0;
      end else if (cmd.scan_step) begin
        cmp_vld_r <= issue_ok;
        if (issue_ok) begin
          scan_cnt_r <= scan_cnt_r + 1'b1;
        end
      end
      if (cmd.wr_op == WR_APPEND) begin
        count_r <= count_r + 1'b1;
      end else if (cmd.wr_op == WR_MOVE) begin
        count_r <= count_r - 1'b1;
      end
      if (cmd.push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.req      = req_r;
  assign sts.hit      = hit;
  assign sts.miss     = !cmp_vld_r && !issue_ok;
  assign sts.full     = is_full;
  assign sts.out_busy = out_valid_r && !out_ready;

  assign out_valid = out_valid_r;
  assign out_found = out_found_r;
  assign out_value = out_value_r;
  assign out_full  = out_full_r;
  assign out_count = out_count_r;

  `KVT_ASSERT(a_count_in_range, count_r <= CNT_W'(CAPACITY), "entry count above capacity")
  `KVT_ASSERT(a_append_not_full, (cmd.wr_op == WR_APPEND) |-> !is_full, "append into full table")
  `KVT_ASSERT(a_push_free, cmd.push |-> !(out_valid_r && !out_ready), "result overwritten")
  `KVT_ASSERT_RST(a_reset_empty, !rst_n |=> (count_r == '0), "table not empty after reset")

endmodule

// File: design/kvt_ctrl.sv
// ---------------------------------------------------------------------------
// Key/value table controller
// Sequences search, write-back and result hand-off for one request at a time.
// ---------------------------------------------------------------------------
`include "key_value_table_unit_defines.svh"

module kvt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  kvt_pkg::kvt_sts_t  sts,
  output kvt_pkg::kvt_cmd_t  cmd
);
  import kvt_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_APPEND,
    ST_FETCH,
    ST_MOVE,
    ST_FINISH
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.req != REQ_LOOKUP && sts.req != REQ_DEFINE && sts.req != REQ_ERASE) begin
          state_nxt = ST_FINISH;
        end else if (sts.hit) begin
          unique case (sts.req)
            REQ_DEFINE: state_nxt = ST_UPDATE;
            REQ_ERASE:  state_nxt = ST_FETCH;
            default:    state_nxt = ST_FINISH;
          endcase
        end else if (sts.miss) begin
          if (sts.req == REQ_DEFINE) begin
            if (sts.full) begin
              cmd.flag_full = 1'b1;
              state_nxt     = ST_FINISH;
            end else begin
              state_nxt = ST_APPEND;
            end
          end else begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_UPDATE: begin
        cmd.wr_op = WR_UPDATE;
        state_nxt = ST_FINISH;
      end
      ST_APPEND: begin
        cmd.wr_op = WR_APPEND;
        state_nxt = ST_FINISH;
      end
      ST_FETCH: begin
        cmd.rd_last = 1'b1;
        state_nxt   = ST_MOVE;
      end
      ST_MOVE: begin
        cmd.wr_op = WR_MOVE;
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (!sts.out_busy) begin
          cmd.push  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `KVT_ASSERT(a_move_fetch, (state_r == ST_MOVE) |-> $past(state_r == ST_FETCH), "stray move")
  `KVT_ASSERT(a_erase_only_moves, (state_r == ST_FETCH) |-> (sts.req == REQ_ERASE), "fetch on non-erase")
  `KVT_ASSERT(a_push_when_free, cmd.push |-> !sts.out_busy, "push while result waits")

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Key/value table unit testbench
// Streams lookup, define, erase and unused-code requests into the table with
// random idling on both sides. A shadow copy of the table predicts each
// response, and every accepted response is compared field by field with the
// oldest prediction.
// ---------------------------------------------------------------------------
module tb;

  import kvt_pkg::*;

  localparam int              CAPACITY     = DEF_CAPACITY;
  localparam logic [REQ_W-1:0] REQ_UNUSED  = 2'd3;
  localparam int              POOL_SIZE    = 24;
  localparam int              RANDOM_ITEMS = 1530;
  localparam int              SEGMENT_LEN  = 64;
  localparam int              DRAIN_CYCLES = 40;
  localparam int              IDLE_LIMIT   = 3000;

  typedef enum int {SEG_FILL, SEG_DRAIN, SEG_MIXED} segment_t;

  typedef struct {
    logic                 found;
    logic [VAL_W-1:0]     read_value;
    logic                 full_error;
    logic [CNT_OUT_W-1:0] entry_count;
  } table_response_t;

  // Shadow of the table contents: predicts one response per accepted request
  // and holds the predictions until the block returns its responses.
  class table_scoreboard;
    logic [KEY_W-1:0] shadow_keys   [CAPACITY];
    logic [VAL_W-1:0] shadow_values [CAPACITY];
    int unsigned      shadow_count;
    table_response_t  awaited_responses[$];
    int unsigned      error_count;

    function void note_request(logic [REQ_W-1:0] kind, logic [KEY_W-1:0] key,
                               logic [VAL_W-1:0] value);
      table_response_t rsp;
      int              slot;
      slot            = -1;
      rsp.found       = 1'b0;
      rsp.read_value  = NO_VALUE;
      rsp.full_error  = 1'b0;
      for (int i = 0; i < int'(shadow_count); i++) begin
        if (slot < 0 && shadow_keys[i] == key) slot = i;
      end
      case (kind)
        REQ_LOOKUP: begin
          if (slot >= 0) begin
            rsp.found      = 1'b1;
            rsp.read_value = shadow_values[slot];
          end
        end
        REQ_DEFINE: begin
          if (slot >= 0) begin
            rsp.found           = 1'b1;
            shadow_values[slot] = value;
          end else if (shadow_count < CAPACITY) begin
            shadow_keys[shadow_count]   = key;
            shadow_values[shadow_count] = value;
            shadow_count++;
          end else begin
            rsp.full_error = 1'b1;
          end
        end
        REQ_ERASE: begin
          // The last entry is moved into the freed slot.
          if (slot >= 0 && shadow_count > 0) begin
            rsp.found           = 1'b1;
            shadow_keys[slot]   = shadow_keys[shadow_count-1];
            shadow_values[slot] = shadow_values[shadow_count-1];
            shadow_count--;
          end
        end
        default: ;
      endcase
      rsp.entry_count = shadow_count[CNT_OUT_W-1:0];
      awaited_responses = {awaited_responses, rsp};
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] tdata,
                               logic [OUT_TUSER_W-1:0] tuser);
      table_response_t exp_rsp;
      if (awaited_responses.size() == 0) begin
        $display("%0t: response with none outstanding: tdata %h tuser %b",
                 $time, tdata, tuser);
        error_count++;
        return;
      end
      exp_rsp = awaited_responses.pop_front();
      if (tuser[0] !== exp_rsp.found) begin
        $display("%0t: found mismatch: expected %b actual %b",
                 $time, exp_rsp.found, tuser[0]);
        error_count++;
      end
      if (tuser[1] !== exp_rsp.full_error) begin
        $display("%0t: full_error mismatch: expected %b actual %b",
                 $time, exp_rsp.full_error, tuser[1]);
        error_count++;
      end
      if (tdata[VAL_W-1:0] !== exp_rsp.read_value) begin
        $display("%0t: read_value mismatch: expected %h actual %h",
                 $time, exp_rsp.read_value, tdata[VAL_W-1:0]);
        error_count++;
      end
      if (tdata[VAL_W +: CNT_OUT_W] !== exp_rsp.entry_count) begin
        $display("%0t: entry_count mismatch: expected %0d actual %0d",
                 $time, exp_rsp.entry_count, tdata[VAL_W +: CNT_OUT_W]);
        error_count++;
      end
    endfunction
  endclass

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [REQ_W-1:0]       in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;

  table_scoreboard  scoreboard = new();
  logic [KEY_W-1:0] key_pool[POOL_SIZE];
  bit               steady_flow = 1'b0;
  int unsigned      stall_left  = 0;
  int unsigned      idle_cycles = 0;

  always #1 clk = ~clk;

  key_value_table_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // Mostly short gaps, now and then a long one; none while the flow is steady.
  function automatic int unsigned gap_length();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (steady_flow || r < 50) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  // Holds the request until it is taken, then notes it for prediction.
  task automatic send_request(input logic [REQ_W-1:0] kind, input logic [KEY_W-1:0] key,
                              input logic [VAL_W-1:0] value);
    int unsigned gap;
    gap = gap_length();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {value, key};
    do @(posedge clk); while (!in_tready);
    scoreboard.note_request(kind, key, value);
  endtask

  // Response side: random back-pressure, checked at each accepted response.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      scoreboard.check_result(out_tdata, out_tuser);
    end
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_tready <= 1'b1;
      stall_left <= gap_length();
    end
  end

  // Ends the run if no request or response moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic run_directed();
    send_request(REQ_LOOKUP, 32'd5, 32'd0);                  // lookup on an empty table
    send_request(REQ_ERASE,  32'd5, 32'd0);                  // erase of an absent key
    send_request(REQ_UNUSED, 32'd0, 32'hFFFF_FFFF);
    send_request(REQ_DEFINE, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(REQ_DEFINE, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(REQ_DEFINE, 32'h0000_0000, 32'h0000_0000);
    send_request(REQ_DEFINE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(REQ_LOOKUP, 32'h8000_0000, 32'h0);
    send_request(REQ_LOOKUP, 32'h7FFF_FFFF, 32'h0);
    send_request(REQ_LOOKUP, 32'hFFFF_FFFF, 32'h0);          // stored value equals no-value
    send_request(REQ_LOOKUP, 32'd12345, 32'h0);              // lookup miss
    send_request(REQ_DEFINE, 32'h0000_0000, 32'h5A5A_5A5A);  // overwrite existing key
    send_request(REQ_LOOKUP, 32'h0000_0000, 32'h0);
    send_request(REQ_ERASE,  32'h8000_0000, 32'h0);          // first slot, last entry moves
    send_request(REQ_LOOKUP, 32'hFFFF_FFFF, 32'h0);
    send_request(REQ_LOOKUP, 32'h8000_0000, 32'h0);
    send_request(REQ_ERASE,  32'h0000_0000, 32'h0);          // erase of the last entry
    send_request(REQ_UNUSED, 32'h7FFF_FFFF, 32'h1234_5678);
    send_request(REQ_ERASE,  32'h7FFF_FFFF, 32'h0);
    send_request(REQ_ERASE,  32'hFFFF_FFFF, 32'h0);
    send_request(REQ_LOOKUP, 32'hFFFF_FFFF, 32'h0);
  endtask

  // Segments bias the mix towards filling or draining the table so that the
  // full case and erases from a crowded table both occur often.
  task automatic run_random();
    segment_t         segment;
    int unsigned      r;
    logic [REQ_W-1:0] kind;
    logic [KEY_W-1:0] key;
    segment = SEG_MIXED;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % SEGMENT_LEN == 0) begin
        segment     = segment_t'($urandom_range(2, 0));
        steady_flow = ($urandom_range(3, 0) == 0);
      end
      r = $urandom_range(99, 0);
      if (r < 3) begin
        kind = REQ_UNUSED;
      end else begin
        case (segment)
          SEG_FILL:  kind = (r < 58) ? REQ_DEFINE : (r < 83) ? REQ_LOOKUP : REQ_ERASE;
          SEG_DRAIN: kind = (r < 23) ? REQ_DEFINE : (r < 48) ? REQ_LOOKUP : REQ_ERASE;
          default:   kind = (r < 38) ? REQ_DEFINE : (r < 70) ? REQ_LOOKUP : REQ_ERASE;
        endcase
      end
      // Defines stay within the pool so that drain segments can empty the table.
      if (kind != REQ_DEFINE && $urandom_range(99, 0) < 15) key = $urandom();
      else key = key_pool[$urandom_range(POOL_SIZE-1, 0)];
      send_request(kind, key, $urandom());
    end
  endtask

  initial begin
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    run_random();
    in_tvalid <= 1'b0;
    steady_flow = 1'b0;
    while (scoreboard.awaited_responses.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (scoreboard.error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/kvt_pkg.sv
design/kvt_dp.sv
design/kvt_ctrl.sv
design/key_value_table_unit.sv
bench/tb.sv
